// ----- src/sft_pkg.sv -----
package sft_pkg;

	// Component format: signed fixed point, CW bits with FB fraction bits.
	localparam int CW = 16;
	localparam int FB = 14;

	// Normalizer internals. Magnitudes are shifted up until the largest one
	// reaches bit NORM_BIT, so the root and the quotient have fixed ranges.
	localparam int NORM_BIT = 30;
	localparam int SHM_W = NORM_BIT + 1;
	localparam int SQ_W = 2 * SHM_W;
	localparam int SUM_W = SQ_W + 2;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int ROOT_W = ROOT_STEPS;
	localparam int NUM_W = SHM_W + FB + 1;
	localparam int Q_W = NUM_W - NORM_BIT;

	// Register stages through one normalizer.
	localparam int U3_LAT = 4 + ROOT_STEPS + 1 + Q_W + 1;

	typedef logic signed [CW-1:0] comp_t;
	typedef comp_t [2:0] vec3_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} u3_stat_t;

	typedef struct packed {
		comp_t normal_x;
		comp_t normal_y;
		comp_t normal_z;
		comp_t vec_x;
		comp_t vec_y;
		comp_t vec_z;
		logic  cmd;
	} item_t;

	typedef struct packed {
		comp_t out_x;
		comp_t out_y;
		comp_t out_z;
		logic  bad_normal;
		logic  saturated;
	} result_t;

endpackage

// ----- src/sft_unit3.sv -----
module sft_unit3 (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 vld,
	input  sft_pkg::vec3_t       a,
	output sft_pkg::u3_stat_t    stat,
	output sft_pkg::vec3_t       u
);
	localparam int CW = sft_pkg::CW;
	localparam int P_W = $clog2(CW);
	localparam int S_W = $clog2(sft_pkg::NORM_BIT + 1);
	localparam int SHM_W = sft_pkg::SHM_W;
	localparam int SQ_W = sft_pkg::SQ_W;
	localparam int SUM_W = sft_pkg::SUM_W;
	localparam int RS = sft_pkg::ROOT_STEPS;
	localparam int ROOT_W = sft_pkg::ROOT_W;
	localparam int NUM_W = sft_pkg::NUM_W;
	localparam int Q_W = sft_pkg::Q_W;
	localparam int D_W = ROOT_W + Q_W;
	localparam int ONE = 1 << sft_pkg::FB;

	// Stage 1: magnitudes and their maximum.
	logic [CW-1:0] mag_c [3];
	logic [CW-1:0] max01_c, max_c;
	logic [CW-1:0] mag_s1 [3];
	logic [CW-1:0] max_s1;
	logic [2:0]    neg_s1;
	logic          vld_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = a[i][CW-1] ? (~a[i] + 1'b1) : a[i];
		end
		max01_c = (mag_c[0] > mag_c[1]) ? mag_c[0] : mag_c[1];
		max_c = (mag_c[2] > max01_c) ? mag_c[2] : max01_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			max_s1 <= max_c;
			neg_s1 <= {a[2][CW-1], a[1][CW-1], a[0][CW-1]};
		end
	end

	// Stage 2: shift all magnitudes so the largest lands on the top bit.
	logic [P_W-1:0]   msb_c;
	logic [S_W-1:0]   sh_c;
	logic [SHM_W-1:0] shm_s2 [3];
	logic [2:0]       neg_s2;
	logic             zero_s2;
	logic             vld_s2;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < CW; i++) begin
			if (max_s1[i]) begin
				msb_c = P_W'(i);
			end
		end
		sh_c = S_W'(sft_pkg::NORM_BIT) - S_W'(msb_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				shm_s2[i] <= SHM_W'(mag_s1[i]) << sh_c;
			end
			neg_s2 <= neg_s1;
			zero_s2 <= (max_s1 == '0);
		end
	end

	// Stage 3: squares.
	logic [SQ_W-1:0]  sq_s3 [3];
	logic [SHM_W-1:0] shm_s3 [3];
	logic [2:0]       neg_s3;
	logic             zero_s3;
	logic             vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= SQ_W'(shm_s2[i]) * SQ_W'(shm_s2[i]);
			end
			shm_s3 <= shm_s2;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4 feeds the square root, which settles one result bit per stage.
	logic [SUM_W-1:0] root_v_s [RS+1];
	logic [SUM_W-1:0] root_r_s [RS+1];
	logic [SHM_W-1:0] root_m_s [RS+1][3];
	logic [2:0]       root_neg_s [RS+1];
	logic             root_zero_s [RS+1];
	logic             root_vld_s [RS+1];
	logic [SUM_W-1:0] root_trial_c [RS];
	logic             root_take_c [RS];

	always_comb begin
		for (int k = 0; k < RS; k++) begin
			root_trial_c[k] = root_r_s[k] + (SUM_W'(1) << (SUM_W - 2 - 2 * k));
			root_take_c[k] = (root_v_s[k] >= root_trial_c[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= RS; k++) begin
				root_vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			root_vld_s[0] <= vld_s3;
			for (int k = 0; k < RS; k++) begin
				root_vld_s[k+1] <= root_vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root_v_s[0] <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			root_r_s[0] <= '0;
			root_m_s[0] <= shm_s3;
			root_neg_s[0] <= neg_s3;
			root_zero_s[0] <= zero_s3;
			for (int k = 0; k < RS; k++) begin
				if (root_take_c[k]) begin
					root_v_s[k+1] <= root_v_s[k] - root_trial_c[k];
					root_r_s[k+1] <= (root_r_s[k] >> 1) + (SUM_W'(1) << (SUM_W - 2 - 2 * k));
				end else begin
					root_v_s[k+1] <= root_v_s[k];
					root_r_s[k+1] <= root_r_s[k] >> 1;
				end
				root_m_s[k+1] <= root_m_s[k];
				root_neg_s[k+1] <= root_neg_s[k];
				root_zero_s[k+1] <= root_zero_s[k];
			end
		end
	end

	// Division: rounded numerator over the length, one quotient bit per stage.
	logic [ROOT_W-1:0] len_c;
	logic [NUM_W-1:0]  div_rem_s [Q_W+1][3];
	logic [Q_W-1:0]    div_q_s [Q_W+1][3];
	logic [ROOT_W-1:0] div_l_s [Q_W+1];
	logic [2:0]        div_neg_s [Q_W+1];
	logic              div_zero_s [Q_W+1];
	logic              div_vld_s [Q_W+1];
	logic [D_W-1:0]    div_d_c [Q_W];
	logic [D_W-1:0]    div_x_c [Q_W][3];
	logic              div_take_c [Q_W][3];

	assign len_c = root_r_s[RS][ROOT_W-1:0];

	always_comb begin
		for (int j = 0; j < Q_W; j++) begin
			div_d_c[j] = D_W'(div_l_s[j]) << (Q_W - 1 - j);
			for (int i = 0; i < 3; i++) begin
				div_x_c[j][i] = D_W'(div_rem_s[j][i]);
				div_take_c[j][i] = (div_x_c[j][i] >= div_d_c[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j <= Q_W; j++) begin
				div_vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			div_vld_s[0] <= root_vld_s[RS];
			for (int j = 0; j < Q_W; j++) begin
				div_vld_s[j+1] <= div_vld_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				div_rem_s[0][i] <= (NUM_W'(root_m_s[RS][i]) << sft_pkg::FB)
					+ NUM_W'(len_c[ROOT_W-1:1]);
				div_q_s[0][i] <= '0;
			end
			div_l_s[0] <= len_c;
			div_neg_s[0] <= root_neg_s[RS];
			div_zero_s[0] <= root_zero_s[RS];
			for (int j = 0; j < Q_W; j++) begin
				for (int i = 0; i < 3; i++) begin
					div_rem_s[j+1][i] <= div_take_c[j][i]
						? NUM_W'(div_x_c[j][i] - div_d_c[j]) : div_rem_s[j][i];
					div_q_s[j+1][i] <= {div_q_s[j][i][Q_W-2:0], div_take_c[j][i]};
				end
				div_l_s[j+1] <= div_l_s[j];
				div_neg_s[j+1] <= div_neg_s[j];
				div_zero_s[j+1] <= div_zero_s[j];
			end
		end
	end

	// Output stage: clamp to one, restore the signs.
	logic [Q_W-1:0] qc_c [3];
	logic [CW-1:0]  qm_c [3];
	logic           vld_o_s;
	logic           zero_o_s;
	sft_pkg::vec3_t u_o_s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc_c[i] = (div_q_s[Q_W][i] > Q_W'(ONE)) ? Q_W'(ONE) : div_q_s[Q_W][i];
			qm_c[i] = CW'(qc_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o_s <= 1'b0;
		end else if (en) begin
			vld_o_s <= div_vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_o_s <= div_zero_s[Q_W];
			for (int i = 0; i < 3; i++) begin
				if (div_zero_s[Q_W]) begin
					u_o_s[i] <= '0;
				end else if (div_neg_s[Q_W][i]) begin
					u_o_s[i] <= ~qm_c[i] + 1'b1;
				end else begin
					u_o_s[i] <= qm_c[i];
				end
			end
		end
	end

	assign stat.valid = vld_o_s;
	assign stat.zero = zero_o_s;
	assign u = u_o_s;

endmodule

// ----- src/shading_frame_transform.sv -----
// Builds an orthonormal shading frame around a surface normal and moves a
// vector into it (cmd 0) or out of it back to world space (cmd 1), all in
// signed Q2.14. A new transaction can be taken every cycle while item_stall
// is low. The two normalizers are each a 32-stage square root followed by
// a 16-stage divider. Results drain through a two-entry output buffer,
// so item_stall rises only after two finished results sit untaken, and the
// whole pipeline then holds in place. A zero normal gives zero outputs with
// bad_normal set; any clipped output component sets saturated.
module shading_frame_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  sft_pkg::item_t      item,
	output logic                result_valid,
	input  logic                result_stall,
	output sft_pkg::result_t    result
);
	localparam int CW = sft_pkg::CW;
	localparam int FB = sft_pkg::FB;
	localparam int LAT = sft_pkg::U3_LAT;
	localparam int ACC_W = 2 * CW;
	localparam logic signed [ACC_W-1:0] ONE = ACC_W'(1 << FB);
	localparam logic signed [ACC_W-1:0] HI = ACC_W'((1 << (CW - 1)) - 1);
	localparam logic signed [ACC_W-1:0] LO = -HI - 1;

	typedef struct packed {
		sft_pkg::vec3_t v;
		logic           cmd;
	} side_t;

	typedef struct packed {
		sft_pkg::vec3_t v;
		logic           cmd;
		sft_pkg::vec3_t z;
		logic           bad;
	} side_b_t;

	function automatic logic signed [ACC_W-1:0] round_fb(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-1:0] m;
		m = v[ACC_W-1] ? (~v + 1'b1) : v;
		m = (m + ACC_W'(1 << (FB - 1))) >> FB;
		return v[ACC_W-1] ? $signed(~m + 1'b1) : $signed(m);
	endfunction

	function automatic logic signed [ACC_W-1:0] clamp_one(input logic signed [ACC_W-1:0] v);
		if (v > ONE) begin
			return ONE;
		end else if (v < -ONE) begin
			return -ONE;
		end
		return v;
	endfunction

	logic en;
	logic [1:0] cnt_q;

	assign en = (cnt_q != 2'd2);
	assign item_stall = !en;

	// Normal to unit z.
	sft_pkg::vec3_t    n_c;
	sft_pkg::vec3_t    z_a;
	sft_pkg::u3_stat_t stat_a;
	side_t             line_a_s [LAT];

	assign n_c[0] = item.normal_x;
	assign n_c[1] = item.normal_y;
	assign n_c[2] = item.normal_z;

	sft_unit3 u_norm_z (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (item_valid),
		.a      (n_c),
		.stat   (stat_a),
		.u      (z_a)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			line_a_s[0].v[0] <= item.vec_x;
			line_a_s[0].v[1] <= item.vec_y;
			line_a_s[0].v[2] <= item.vec_z;
			line_a_s[0].cmd <= item.cmd;
			for (int k = 1; k < LAT; k++) begin
				line_a_s[k] <= line_a_s[k-1];
			end
		end
	end

	// Tangent choice.
	logic [CW-1:0]  abs_zx_c, abs_zy_c;
	logic           pick_c;
	sft_pkg::vec3_t t_c;
	sft_pkg::vec3_t t_b1;
	side_b_t        side_b1;
	logic           vld_b1;

	always_comb begin
		abs_zx_c = z_a[0][CW-1] ? (~z_a[0] + 1'b1) : z_a[0];
		abs_zy_c = z_a[1][CW-1] ? (~z_a[1] + 1'b1) : z_a[1];
		pick_c = (abs_zx_c > abs_zy_c);
		if (pick_c) begin
			t_c[0] = ~z_a[2] + 1'b1;
			t_c[1] = '0;
			t_c[2] = z_a[0];
		end else begin
			t_c[0] = '0;
			t_c[1] = z_a[2];
			t_c[2] = ~z_a[1] + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_b1 <= 1'b0;
		end else if (en) begin
			vld_b1 <= stat_a.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_b1 <= t_c;
			side_b1.v <= line_a_s[LAT-1].v;
			side_b1.cmd <= line_a_s[LAT-1].cmd;
			side_b1.z <= z_a;
			side_b1.bad <= stat_a.zero;
		end
	end

	// Tangent to unit x.
	sft_pkg::vec3_t    x_b;
	sft_pkg::u3_stat_t stat_b;
	side_b_t           line_b_s [LAT];

	sft_unit3 u_norm_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld    (vld_b1),
		.a      (t_b1),
		.stat   (stat_b),
		.u      (x_b)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			line_b_s[0] <= side_b1;
			for (int k = 1; k < LAT; k++) begin
				line_b_s[k] <= line_b_s[k-1];
			end
		end
	end

	// Cross product y = z x x over three stages.
	logic signed [ACC_W-1:0] prod_c1 [6];
	sft_pkg::vec3_t          x_c1, x_c2, x_c3;
	side_b_t                 side_c1, side_c2, side_c3;
	logic signed [ACC_W-1:0] diff_c2 [3];
	sft_pkg::vec3_t          y_c3;
	logic                    vld_c1, vld_c2, vld_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
		end else if (en) begin
			vld_c1 <= stat_b.valid;
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_c1[0] <= $signed(line_b_s[LAT-1].z[1]) * $signed(x_b[2]);
			prod_c1[1] <= $signed(line_b_s[LAT-1].z[2]) * $signed(x_b[1]);
			prod_c1[2] <= $signed(line_b_s[LAT-1].z[2]) * $signed(x_b[0]);
			prod_c1[3] <= $signed(line_b_s[LAT-1].z[0]) * $signed(x_b[2]);
			prod_c1[4] <= $signed(line_b_s[LAT-1].z[0]) * $signed(x_b[1]);
			prod_c1[5] <= $signed(line_b_s[LAT-1].z[1]) * $signed(x_b[0]);
			x_c1 <= x_b;
			side_c1 <= line_b_s[LAT-1];

			for (int i = 0; i < 3; i++) begin
				diff_c2[i] <= prod_c1[2*i] - prod_c1[2*i+1];
			end
			x_c2 <= x_c1;
			side_c2 <= side_c1;

			for (int i = 0; i < 3; i++) begin
				y_c3[i] <= CW'(clamp_one(round_fb(diff_c2[i])));
			end
			x_c3 <= x_c2;
			side_c3 <= side_c2;
		end
	end

	// Transform: r[i] = sum over j of v[j] * coef[i][j], with the axis matrix
	// used as rows for a projection and as columns for the way back.
	sft_pkg::vec3_t          axis_c [3];
	logic signed [CW-1:0]    coef_c [3][3];
	logic signed [ACC_W-1:0] prod_d1 [3][3];
	logic signed [ACC_W-1:0] sum_d2 [3];
	logic                    bad_d1, bad_d2;
	logic                    vld_d1, vld_d2, vld_d3;
	logic signed [ACC_W-1:0] rnd_c [3];
	logic [2:0]              clip_c;
	sft_pkg::result_t        res_c;
	sft_pkg::result_t        res_d3;

	always_comb begin
		axis_c[0] = x_c3;
		axis_c[1] = y_c3;
		axis_c[2] = side_c3.z;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				coef_c[i][j] = side_c3.cmd ? axis_c[j][i] : axis_c[i][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_d1 <= 1'b0;
			vld_d2 <= 1'b0;
			vld_d3 <= 1'b0;
		end else if (en) begin
			vld_d1 <= vld_c3;
			vld_d2 <= vld_d1;
			vld_d3 <= vld_d2;
		end
	end

	always_comb begin
		res_c = '0;
		for (int i = 0; i < 3; i++) begin
			rnd_c[i] = round_fb(sum_d2[i]);
			clip_c[i] = (rnd_c[i] > HI) || (rnd_c[i] < LO);
		end
		res_c.out_x = (rnd_c[0] > HI) ? CW'(HI) : (rnd_c[0] < LO) ? CW'(LO) : CW'(rnd_c[0]);
		res_c.out_y = (rnd_c[1] > HI) ? CW'(HI) : (rnd_c[1] < LO) ? CW'(LO) : CW'(rnd_c[1]);
		res_c.out_z = (rnd_c[2] > HI) ? CW'(HI) : (rnd_c[2] < LO) ? CW'(LO) : CW'(rnd_c[2]);
		res_c.saturated = |clip_c;
		if (bad_d2) begin
			res_c = '0;
			res_c.bad_normal = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_d1[i][j] <= $signed(side_c3.v[j]) * coef_c[i][j];
				end
			end
			bad_d1 <= side_c3.bad;

			for (int i = 0; i < 3; i++) begin
				sum_d2[i] <= prod_d1[i][0] + prod_d1[i][1] + prod_d1[i][2];
			end
			bad_d2 <= bad_d1;

			res_d3 <= res_c;
		end
	end

	// Two-entry output buffer.
	sft_pkg::result_t buf_q [2];
	logic             wr_q, rd_q;
	logic             push, pop;

	assign push = en && vld_d3;
	assign result_valid = (cnt_q != 2'd0);
	assign pop = result_valid && !result_stall;
	assign result = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= res_d3;
		end
	end

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_normal |-> result.out_x == '0 && result.out_y == '0
			&& result.out_z == '0 && !result.saturated)
		else $error("bad normal transaction carries nonzero data");

	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_hold_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_d3) && $stable(res_d3))
		else $error("pipeline moved while the output buffer was full");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("pushed result not counted");

endmodule

// ----- tb/shading_frame_transform_test.sv -----
module shading_frame_transform_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 2 * sft_pkg::U3_LAT + 7;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic CMD_TO_LOCAL = 1'b0;
	localparam logic CMD_TO_WORLD = 1'b1;
	localparam longint ONE = 64'sd1 <<< sft_pkg::FB;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	sft_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	sft_pkg::result_t result;

	shading_frame_transform DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	sft_pkg::item_t pending_items[$];
	sft_pkg::result_t expected_results[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_cycles = 0;
	int errors = 0;
	int checked = 0;
	int saturated_seen = 0;
	int bad_seen = 0;
	longint cycles = 0;

	function automatic longint clamp_one(longint v);
		if (v > ONE) return ONE;
		if (v < -ONE) return -ONE;
		return v;
	endfunction

	function automatic longint rounded_shift(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (sft_pkg::FB - 1))) >>> sft_pkg::FB;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// Returns 0 when the vector is all zero; unit components otherwise.
	function automatic bit unit_vector(input longint a[3], output longint u[3]);
		longint unsigned mags[3], m, total, len, q;
		int s;
		m = 0;
		total = 0;
		for (int i = 0; i < 3; i++) begin
			mags[i] = (a[i] < 0) ? -a[i] : a[i];
			if (mags[i] > m) m = mags[i];
			u[i] = 0;
		end
		if (m == 0) return 1'b0;
		s = 0;
		while ((m << s) < (64'd1 << 30)) s++;
		for (int i = 0; i < 3; i++) begin
			mags[i] = mags[i] << s;
			total += mags[i] * mags[i];
		end
		len = root_floor(total);
		if (len == 0) return 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = (mags[i] * longint'(ONE) + len / 2) / len;
			u[i] = clamp_one((a[i] < 0) ? -longint'(q) : longint'(q));
		end
		return 1'b1;
	endfunction

	function automatic sft_pkg::result_t transform_vector(sft_pkg::item_t it);
		longint n[3], v[3], z[3], t[3], ax[3], ay[3], r[3], c;
		longint hi, lo;
		sft_pkg::result_t res;
		hi = (64'sd1 <<< (sft_pkg::CW - 1)) - 1;
		lo = -hi - 1;
		res = '0;
		n = '{longint'(it.normal_x), longint'(it.normal_y), longint'(it.normal_z)};
		v = '{longint'(it.vec_x), longint'(it.vec_y), longint'(it.vec_z)};
		if (!unit_vector(n, z)) begin
			res.bad_normal = 1'b1;
			return res;
		end
		if (((z[0] < 0) ? -z[0] : z[0]) > ((z[1] < 0) ? -z[1] : z[1]))
			t = '{-z[2], 0, z[0]};
		else
			t = '{0, z[2], -z[1]};
		void'(unit_vector(t, ax));
		ay[0] = clamp_one(rounded_shift(z[1] * ax[2] - z[2] * ax[1]));
		ay[1] = clamp_one(rounded_shift(z[2] * ax[0] - z[0] * ax[2]));
		ay[2] = clamp_one(rounded_shift(z[0] * ax[1] - z[1] * ax[0]));
		if (it.cmd == CMD_TO_LOCAL) begin
			r[0] = v[0] * ax[0] + v[1] * ax[1] + v[2] * ax[2];
			r[1] = v[0] * ay[0] + v[1] * ay[1] + v[2] * ay[2];
			r[2] = v[0] * z[0] + v[1] * z[1] + v[2] * z[2];
		end else begin
			for (int i = 0; i < 3; i++)
				r[i] = ax[i] * v[0] + ay[i] * v[1] + z[i] * v[2];
		end
		for (int i = 0; i < 3; i++) begin
			c = rounded_shift(r[i]);
			if (c > hi) begin
				c = hi;
				res.saturated = 1'b1;
			end else if (c < lo) begin
				c = lo;
				res.saturated = 1'b1;
			end
			case (i)
				0: res.out_x = sft_pkg::comp_t'(c);
				1: res.out_y = sft_pkg::comp_t'(c);
				default: res.out_z = sft_pkg::comp_t'(c);
			endcase
		end
		return res;
	endfunction

	// Driver: a transaction completes at a rising edge with valid high and no stall.
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			expected_results.push_back(transform_vector(item));
			void'(pending_items.pop_front());
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(item_valid && item_stall)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= pending_items[0];
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random idling, or a long hold counted down here.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// The driver pops only after acceptance, so the head item is what is on the bus.
	// Monitor.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				sft_pkg::result_t e;
				e = expected_results.pop_front();
				checked++;
				if (e.bad_normal) bad_seen++;
				if (e.saturated) saturated_seen++;
				if (result.out_x !== e.out_x) begin
					$error("out_x expected %0d got %0d", e.out_x, result.out_x);
					errors++;
				end
				if (result.out_y !== e.out_y) begin
					$error("out_y expected %0d got %0d", e.out_y, result.out_y);
					errors++;
				end
				if (result.out_z !== e.out_z) begin
					$error("out_z expected %0d got %0d", e.out_z, result.out_z);
					errors++;
				end
				if (result.bad_normal !== e.bad_normal) begin
					$error("bad_normal expected %0b got %0b", e.bad_normal, result.bad_normal);
					errors++;
				end
				if (result.saturated !== e.saturated) begin
					$error("saturated expected %0b got %0b", e.saturated, result.saturated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic sft_pkg::comp_t edge_value(int k);
		case (k)
			0: return sft_pkg::comp_t'(-32768);
			1: return sft_pkg::comp_t'(32767);
			2: return sft_pkg::comp_t'(0);
			3: return sft_pkg::comp_t'(-1);
			4: return sft_pkg::comp_t'(1);
			default: return sft_pkg::comp_t'($urandom);
		endcase
	endfunction

	function automatic sft_pkg::item_t random_item();
		sft_pkg::item_t it;
		it = '0;
		it.cmd = 1'($urandom_range(1));
		it.vec_x = sft_pkg::comp_t'($urandom);
		it.vec_y = sft_pkg::comp_t'($urandom);
		it.vec_z = sft_pkg::comp_t'($urandom);
		if ($urandom_range(7) == 0) begin
			it.normal_x = edge_value($urandom_range(5));
			it.normal_y = edge_value($urandom_range(5));
			it.normal_z = edge_value($urandom_range(5));
			it.vec_x = edge_value($urandom_range(5));
		end else if ($urandom_range(3) == 0) begin
			// Short normals stress the normalizer shift.
			it.normal_x = sft_pkg::comp_t'($signed($urandom_range(64)) - 32);
			it.normal_y = sft_pkg::comp_t'($signed($urandom_range(64)) - 32);
			it.normal_z = sft_pkg::comp_t'($signed($urandom_range(64)) - 32);
		end else begin
			it.normal_x = sft_pkg::comp_t'($urandom);
			it.normal_y = sft_pkg::comp_t'($urandom);
			it.normal_z = sft_pkg::comp_t'($urandom);
		end
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() > 0 || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		sft_pkg::item_t it;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero normal, normals with one component at one or minus one, extremes, both commands.
		for (int k = 0; k < 20; k++) begin
			it.normal_x = (k % 4 == 1) ? sft_pkg::comp_t'(16384) : edge_value((k * 3) % 5);
			it.normal_y = (k % 4 == 2) ? sft_pkg::comp_t'(-16384)
				: edge_value((k * 7 + 1) % 5);
			it.normal_z = (k % 4 == 3) ? sft_pkg::comp_t'(16384) : edge_value((k + 2) % 5);
			if (k < 2) begin
				it.normal_x = '0;
				it.normal_y = '0;
				it.normal_z = '0;
			end
			it.vec_x = edge_value(k % 2);
			it.vec_y = edge_value((k + 1) % 2);
			it.vec_z = edge_value(k % 5);
			it.cmd = k[0] ? CMD_TO_WORLD : CMD_TO_LOCAL;
			pending_items.push_back(it);
		end
		wait_drained();

		send_idle_pct = 21;
		recv_idle_pct = 86;
		for (int k = 0; k < 130; k++) pending_items.push_back(random_item());
		wait_drained();

		send_idle_pct = 86;
		recv_idle_pct = 21;
		for (int k = 0; k < 130; k++) pending_items.push_back(random_item());
		wait_drained();

		// Back-pressure: the receiver holds off long enough to fill the pipeline.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles = 3 * LATENCY;
		for (int k = 0; k < 140; k++) pending_items.push_back(random_item());
		wait_drained();

		repeat (LATENCY + 10) @(posedge clk);
		$display("checked %0d results, %0d zero normals, %0d saturated",
			checked, bad_seen, saturated_seen);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
